FILE: rtl/sdk_pkg.sv
// shared types, constants and rounding helper for the sidechain ducker
`default_nettype none

package sdk_pkg;

	// field widths
	localparam int SAMPLE_BITS  = 24;
	localparam int MAX_CHANNELS = 4;
	localparam int HOLD_BITS    = 20;
	localparam int COEF_BITS    = 24;
	localparam int COEF_FRAC    = 23;
	localparam int CH_BITS      = 3;
	localparam int LEVEL_BITS   = SAMPLE_BITS - 1;

	// configuration port
	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_DATA_BITS = 24;

	// product and rounded product widths
	localparam int PROD_BITS = 2 * (COEF_BITS + 1);
	localparam int RND_BITS  = PROD_BITS - COEF_FRAC;

	// stream widths, padded to whole bytes
	localparam int IN_RAW   = (MAX_CHANNELS + 1) * SAMPLE_BITS;
	localparam int IN_BITS  = ((IN_RAW + 7) / 8) * 8;
	localparam int OUT_RAW  = MAX_CHANNELS * SAMPLE_BITS + COEF_BITS + 1;
	localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8;

	// q1.23 constants
	localparam logic [COEF_BITS-1:0] UNITY        = COEF_BITS'(1) << COEF_FRAC;
	localparam logic [COEF_BITS-1:0] ATTACK_FIXED = COEF_BITS'(2860515);

	// register indexes
	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_THRESHOLD = 3'd0,
		REG_RANGE     = 3'd1,
		REG_ATTACK    = 3'd2,
		REG_DECAY     = 3'd3,
		REG_RELEASE   = 3'd4,
		REG_HOLD      = 3'd5,
		REG_CHANNELS  = 3'd6
	} cfg_reg_t;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [COEF_BITS-1:0] coef_t;

	// sequencer to lanes and output stage
	typedef struct packed {
		logic  mul_en;
		logic  out_load;
		logic  ducking;
		coef_t gain;
	} lane_ctl_t;

	// floor((p + 2^22) / 2^23)
	function automatic logic signed [RND_BITS-1:0] q_round(input logic signed [PROD_BITS-1:0] p);
		logic signed [PROD_BITS-1:0] t;
		t = p + (PROD_BITS'(1) << (COEF_FRAC - 1));
		return t[PROD_BITS-1:COEF_FRAC];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/sidechain_audio_ducker.sv
// top level of the sidechain ducker with hold: config registers, lanes, output
// Usage:
// Frames enter on the s_axis channel: sidechain sample and four audio samples,
// signed Q1.23. Results leave on the m_axis channel: four ducked samples, the
// gain applied to the frame (unsigned Q1.23) and the ducking flag.
// Settings are written through cfg_we/cfg_addr/cfg_data while no frame is in
// flight; an index past the register list is ignored.
// For each frame the sequencer walks the level follower, hold counter and gain
// glide through one shared multiplier, then the four channel lanes multiply in
// parallel. m_axis_tvalid rises once the result is loaded into the output
// register, and s_axis_tready returns in that same cycle.
// A new frame is taken while a finished result still waits in the output
// register; if the receiver stalls, the next frame completes up to the
// output stage and waits there, holding s_axis_tready low until the slot frees.
// Reset clears the follower level and hold count, sets the gain to unity and
// loads the registers with their defaults (unity coefficients and threshold,
// no hold, four channels); the output register comes up empty.
`default_nettype none

module sidechain_audio_ducker
	import sdk_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_axis_tvalid,
	output logic                          s_axis_tready,
	// sidechain_sample, audio_0, audio_1, audio_2, audio_3
	input  wire logic [IN_BITS-1:0]       s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  wire logic                     m_axis_tready,
	// ducked_0, ducked_1, ducked_2, ducked_3, frame_gain, ducking_flag, zero pad
	output logic [OUT_BITS-1:0]           m_axis_tdata,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

	coef_t                threshold_q;
	coef_t                range_q;
	coef_t                attack_q;
	coef_t                decay_q;
	coef_t                release_q;
	logic [HOLD_BITS-1:0] hold_samples_q;
	logic [CH_BITS-1:0]   channels_q;

	logic      in_xfer;
	logic      busy;
	logic      out_free;
	lane_ctl_t ctl;
	sample_t   lane_y [MAX_CHANNELS];

	assign s_axis_tready = !busy;
	assign in_xfer       = s_axis_tvalid && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q    <= UNITY;
			range_q        <= UNITY;
			attack_q       <= UNITY;
			decay_q        <= UNITY;
			release_q      <= UNITY;
			hold_samples_q <= '0;
			channels_q     <= CH_BITS'(MAX_CHANNELS);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_THRESHOLD: threshold_q    <= cfg_data[COEF_BITS-1:0];
				REG_RANGE:     range_q        <= cfg_data[COEF_BITS-1:0];
				REG_ATTACK:    attack_q       <= cfg_data[COEF_BITS-1:0];
				REG_DECAY:     decay_q        <= cfg_data[COEF_BITS-1:0];
				REG_RELEASE:   release_q      <= cfg_data[COEF_BITS-1:0];
				REG_HOLD:      hold_samples_q <= cfg_data[HOLD_BITS-1:0];
				REG_CHANNELS:  channels_q     <= cfg_data[CH_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// envelope, hold and gain sequencer
	sdk_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (in_xfer),
		.side         (s_axis_tdata[SAMPLE_BITS-1:0]),
		.threshold    (threshold_q),
		.range_gain   (range_q),
		.attack_coef  (attack_q),
		.decay_coef   (decay_q),
		.release_coef (release_q),
		.hold_samples (hold_samples_q),
		.out_free     (out_free),
		.busy         (busy),
		.ctl          (ctl)
	);

	// channel lanes
	for (genvar ch = 0; ch < MAX_CHANNELS; ch++) begin : g_lane
		sdk_lane u_lane (
			.clk       (clk),
			.load      (in_xfer),
			.sample_in (s_axis_tdata[(ch+1)*SAMPLE_BITS +: SAMPLE_BITS]),
			.en        (channels_q > CH_BITS'(ch)),
			.ctl       (ctl),
			.y         (lane_y[ch])
		);
	end

	// output merge and register
	sdk_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.lane_y        (lane_y),
		.m_axis_tready (m_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tdata  (m_axis_tdata),
		.out_free      (out_free)
	);

endmodule

`default_nettype wire

FILE: rtl/sdk_ctrl.sv
// sequencer with level follower, hold counter and gain glide
`default_nettype none

module sdk_ctrl
	import sdk_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire sample_t              side,
	input  wire coef_t                threshold,
	input  wire coef_t                range_gain,
	input  wire coef_t                attack_coef,
	input  wire coef_t                decay_coef,
	input  wire coef_t                release_coef,
	input  wire logic [HOLD_BITS-1:0] hold_samples,
	input  wire logic                 out_free,
	output logic                      busy,
	output lane_ctl_t                 ctl
);

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_ENV_MUL  = 8'b0000_0010,
		ST_ENV_ADD  = 8'b0000_0100,
		ST_HOLD     = 8'b0000_1000,
		ST_GAIN_MUL = 8'b0001_0000,
		ST_GAIN_ADD = 8'b0010_0000,
		ST_LANE_MUL = 8'b0100_0000,
		ST_LANE_OUT = 8'b1000_0000
	} state_t;

	function automatic coef_t clamp_unity(input coef_t c);
		return (c > UNITY) ? UNITY : c;
	endfunction

	state_t                          state_q;
	sample_t                         side_q;
	logic [LEVEL_BITS-1:0]           env_q;
	logic [HOLD_BITS-1:0]            hold_q;
	coef_t                           gain_q;
	logic                            ducking_q;
	coef_t                           target_q;
	coef_t                           coef_q;
	logic signed [PROD_BITS-1:0]     prod_q;

	logic [SAMPLE_BITS-1:0]          mag;
	logic [LEVEL_BITS-1:0]           level;
	logic signed [COEF_BITS:0]       mul_a;
	coef_t                           mul_b;
	logic signed [COEF_BITS:0]       mul_bs;
	logic signed [PROD_BITS-1:0]     mul_p;
	logic signed [RND_BITS-1:0]      env_sum;
	logic signed [RND_BITS-1:0]      gain_sum;
	logic                            active;
	logic [HOLD_BITS-1:0]            hold_next;

	// rectify the sidechain, full-scale negative saturates
	assign mag   = side_q[SAMPLE_BITS-1] ? (~side_q + 1'b1) : side_q;
	assign level = mag[SAMPLE_BITS-1] ? {LEVEL_BITS{1'b1}} : mag[LEVEL_BITS-1:0];

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_ENV_MUL) begin
			mul_a = {2'b00, level} - {2'b00, env_q};
			mul_b = (level > env_q) ? ATTACK_FIXED : clamp_unity(release_coef);
		end else begin
			mul_a = {1'b0, target_q} - {1'b0, gain_q};
			mul_b = coef_q;
		end
	end

	assign mul_bs = {1'b0, mul_b};
	assign mul_p  = mul_a * mul_bs;

	// follower and gain updates from the registered product
	assign env_sum  = RND_BITS'({1'b0, env_q}) + q_round(prod_q);
	assign gain_sum = RND_BITS'({1'b0, gain_q}) + q_round(prod_q);

	// threshold compare and hold countdown
	assign active = {1'b0, env_q} >= threshold;
	always_comb begin
		if (active) begin
			hold_next = hold_samples;
		end else if (hold_q != '0) begin
			hold_next = hold_q - 1'b1;
		end else begin
			hold_next = '0;
		end
	end

	// sequencer and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			env_q     <= '0;
			hold_q    <= '0;
			gain_q    <= UNITY;
			ducking_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_ENV_MUL;
					end
				end
				ST_ENV_MUL: begin
					state_q <= ST_ENV_ADD;
				end
				ST_ENV_ADD: begin
					env_q   <= env_sum[LEVEL_BITS-1:0];
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					hold_q    <= hold_next;
					ducking_q <= active | (hold_next != '0);
					state_q   <= ST_GAIN_MUL;
				end
				ST_GAIN_MUL: begin
					state_q <= ST_GAIN_ADD;
				end
				ST_GAIN_ADD: begin
					if (gain_sum < 0) begin
						gain_q <= '0;
					end else if (gain_sum > RND_BITS'(UNITY)) begin
						gain_q <= UNITY;
					end else begin
						gain_q <= gain_sum[COEF_BITS-1:0];
					end
					state_q <= ST_LANE_MUL;
				end
				ST_LANE_MUL: begin
					state_q <= ST_LANE_OUT;
				end
				ST_LANE_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			side_q <= side;
		end
		if (state_q == ST_ENV_MUL || state_q == ST_GAIN_MUL) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_HOLD) begin
			if (active | (hold_next != '0)) begin
				target_q <= clamp_unity(range_gain);
				coef_q   <= clamp_unity(attack_coef);
			end else begin
				target_q <= UNITY;
				coef_q   <= clamp_unity(decay_coef);
			end
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign ctl.mul_en   = (state_q == ST_LANE_MUL);
	assign ctl.out_load = (state_q == ST_LANE_OUT) && out_free;
	assign ctl.ducking  = ducking_q;
	assign ctl.gain     = gain_q;

endmodule

`default_nettype wire

FILE: rtl/sdk_lane.sv
// one channel lane: sample capture, gain multiply, rounding and saturation
`default_nettype none

module sdk_lane
	import sdk_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      load,
	input  wire sample_t   sample_in,
	input  wire logic      en,
	input  wire lane_ctl_t ctl,
	output sample_t        y
);

	sample_t                     sample_q;
	logic signed [PROD_BITS-1:0] prod_q;
	logic signed [COEF_BITS:0]   gain_s;
	logic signed [RND_BITS-1:0]  r;

	assign gain_s = {1'b0, ctl.gain};

	// capture sample on transfer, multiply when the gain is ready
	always_ff @(posedge clk) begin
		if (load) begin
			sample_q <= sample_in;
		end
		if (ctl.mul_en) begin
			prod_q <= sample_q * gain_s;
		end
	end

	assign r = q_round(prod_q);

	// saturate to the sample range, inactive channel gives zero
	always_comb begin
		if (!en) begin
			y = '0;
		end else if (r[RND_BITS-1:SAMPLE_BITS-1] !=
				{(RND_BITS-SAMPLE_BITS+1){r[RND_BITS-1]}}) begin
			y = r[RND_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
			                  : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end else begin
			y = r[SAMPLE_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sdk_merge.sv
// merges lane results, gain and flag into the output register
`default_nettype none

module sdk_merge
	import sdk_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire lane_ctl_t     ctl,
	input  wire sample_t       lane_y [MAX_CHANNELS],
	input  wire logic          m_axis_tready,
	output logic               m_axis_tvalid,
	output logic [OUT_BITS-1:0] m_axis_tdata,
	output logic               out_free
);

	logic [OUT_BITS-1:0] packed_d;
	logic [OUT_BITS-1:0] data_q;
	logic                valid_q;

	// pack channels from the lowest bits up, then gain and flag
	always_comb begin
		packed_d = '0;
		for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
			packed_d[ch*SAMPLE_BITS +: SAMPLE_BITS] = lane_y[ch];
		end
		packed_d[MAX_CHANNELS*SAMPLE_BITS +: COEF_BITS] = ctl.gain;
		packed_d[MAX_CHANNELS*SAMPLE_BITS + COEF_BITS]  = ctl.ducking;
	end

	// output slot, frees on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			data_q <= packed_d;
		end
	end

	assign out_free      = !valid_q || m_axis_tready;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// self-checking testbench for the sidechain audio ducker: frame stream in, ducked frames out
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sdk_pkg::*;

	localparam int RUN_LIMIT    = 500000;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_OFF_LEN = 200;
	localparam logic [CFG_ADDR_BITS-1:0] REG_UNUSED = 3'd7;

	localparam sample_t S_MIN = 24'h800000;
	localparam sample_t S_MAX = 24'h7FFFFF;

	localparam longint UNITY_Q   = longint'(UNITY);
	localparam longint HALF_LSB  = longint'(1) <<< (COEF_FRAC - 1);
	localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_LO = -(longint'(1) <<< (SAMPLE_BITS - 1));

	// sidechain shapes for the random program
	typedef enum int {SC_QUIET, SC_LOUD, SC_ANY, SC_MID} scene_t;

	// input frame, sidechain in the lowest bits
	typedef struct packed {
		sample_t [MAX_CHANNELS-1:0] audio;
		sample_t                    side;
	} frame_t;

	// output frame, ducked_0 in the lowest bits
	typedef struct packed {
		logic                       ducking;
		coef_t                      gain;
		sample_t [MAX_CHANNELS-1:0] ducked;
	} ducked_frame_t;

	typedef struct packed {
		coef_t                thresh;
		coef_t                range_gain;
		coef_t                attack_k;
		coef_t                decay_k;
		coef_t                release_k;
		logic [HOLD_BITS-1:0] hold_len;
		logic [CH_BITS-1:0]   chan_count;
	} ducker_regs_t;

	localparam ducker_regs_t REGS_AT_RESET = '{thresh: UNITY, range_gain: UNITY,
		attack_k: UNITY, decay_k: UNITY, release_k: UNITY, hold_len: '0, chan_count: 3'd4};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [IN_BITS-1:0]       s_axis_tdata = '0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [OUT_BITS-1:0]      m_axis_tdata;
	logic                     cfg_we = 1'b0;
	logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	// gain computer copy: registers and state
	ducker_regs_t regs_now = REGS_AT_RESET;
	longint       env_level = 0;
	longint       hold_left = 0;
	longint       gain_now = UNITY_Q;

	ducked_frame_t expected_q[$];

	int     frames_sent = 0;
	int     results_checked = 0;
	int     ducking_seen = 0;
	int     mismatch_count = 0;
	int     cycle_count = 0;
	int     stall_budget = 0;
	int     phases_run = 0;
	bit     steady_flow = 1'b0;
	scene_t scene = SC_QUIET;
	int     scene_left = 0;

	sidechain_audio_ducker uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// q1.23 product, rounded half up
	function automatic longint qscale(longint v, longint k);
		return (v * k + HALF_LSB) >>> COEF_FRAC;
	endfunction

	function automatic longint cap_unity(coef_t c);
		return (longint'(c) > UNITY_Q) ? UNITY_Q : longint'(c);
	endfunction

	// follower, hold, gain glide and channel gain for one frame
	function automatic ducked_frame_t duck_frame(frame_t f);
		ducked_frame_t r;
		longint level, k, target, c, g, y;
		bit active, ducking;
		level = longint'($signed(f.side));
		if (level < 0) level = -level;
		if (level > SAMPLE_HI) level = SAMPLE_HI;
		k = (level > env_level) ? longint'(ATTACK_FIXED) : cap_unity(regs_now.release_k);
		env_level = env_level + qscale(level - env_level, k);
		active = env_level >= longint'(regs_now.thresh);
		if (active) hold_left = longint'(regs_now.hold_len);
		else if (hold_left > 0) hold_left = hold_left - 1;
		ducking = active || (hold_left > 0);
		if (ducking) begin
			target = cap_unity(regs_now.range_gain);
			c = cap_unity(regs_now.attack_k);
		end else begin
			target = UNITY_Q;
			c = cap_unity(regs_now.decay_k);
		end
		g = gain_now + qscale(target - gain_now, c);
		if (g < 0) g = 0;
		if (g > UNITY_Q) g = UNITY_Q;
		gain_now = g;
		for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
			y = 0;
			if (ch < int'(regs_now.chan_count)) begin
				y = qscale(longint'($signed(f.audio[ch])), g);
				if (y > SAMPLE_HI) y = SAMPLE_HI;
				if (y < SAMPLE_LO) y = SAMPLE_LO;
			end
			r.ducked[ch] = sample_t'(y);
		end
		r.gain = coef_t'(g);
		r.ducking = ducking;
		return r;
	endfunction

	function automatic sample_t rand_sample();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(15))
			0: return S_MIN;
			1: return S_MAX;
			2: return '0;
			default: return sample_t'(r[23:0]);
		endcase
	endfunction

	function automatic sample_t signed_in_range(int unsigned lo, int unsigned hi);
		longint v;
		v = longint'($urandom_range(hi, lo));
		if ($urandom_range(1) == 1) v = -v;
		return sample_t'(v);
	endfunction

	// sidechain walks through quiet and loud stretches so ducking toggles
	function automatic sample_t next_sidechain();
		if (scene_left == 0) begin
			scene = scene_t'($urandom_range(3));
			scene_left = $urandom_range(30, 1);
		end
		scene_left = scene_left - 1;
		case (scene)
			SC_QUIET: return signed_in_range(0, 'h3FFF);
			SC_LOUD:  return ($urandom_range(20) == 0) ? S_MIN : signed_in_range('h200000, 'h7FFFFF);
			SC_MID:   return signed_in_range(0, 'h400000);
			default:  return rand_sample();
		endcase
	endfunction

	function automatic frame_t make_frame(sample_t side, sample_t a0, sample_t a1,
		sample_t a2, sample_t a3);
		frame_t f;
		f.side = side;
		f.audio[0] = a0;
		f.audio[1] = a1;
		f.audio[2] = a2;
		f.audio[3] = a3;
		return f;
	endfunction

	function automatic frame_t random_frame();
		return make_frame(next_sidechain(), rand_sample(), rand_sample(), rand_sample(),
			rand_sample());
	endfunction

	function automatic coef_t pick_coef();
		case ($urandom_range(7))
			0: return UNITY;
			1: return coef_t'($urandom());
			2: return '0;
			default: return coef_t'($urandom_range('h800000, 0));
		endcase
	endfunction

	function automatic ducker_regs_t random_settings();
		ducker_regs_t s;
		case ($urandom_range(7))
			0: s.thresh = '0;
			1: s.thresh = coef_t'($urandom());
			2: s.thresh = UNITY;
			default: s.thresh = coef_t'($urandom_range('h600000, 'h10000));
		endcase
		s.range_gain = pick_coef();
		s.attack_k = pick_coef();
		s.decay_k = pick_coef();
		s.release_k = pick_coef();
		s.hold_len = ($urandom_range(5) == 0) ? HOLD_BITS'($urandom())
			: HOLD_BITS'($urandom_range(40, 0));
		s.chan_count = CH_BITS'($urandom_range(7, 0));
		return s;
	endfunction

	// one frame transfer on the input side, with random gaps
	task automatic send_frame(frame_t f);
		if (!steady_flow && $urandom_range(99) < 28) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(12, 1)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= f;
		do @(posedge clk); while (!s_axis_tready);
		expected_q.push_back(duck_frame(f));
		frames_sent++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write enable stays high across back-to-back writes
	task automatic write_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [CFG_DATA_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// upper data bits of the narrow registers carry junk that must be dropped
	task automatic apply_settings(ducker_regs_t s, bit poke_unused);
		logic [31:0] junk;
		wait_drained();
		junk = $urandom();
		write_reg(REG_THRESHOLD, s.thresh);
		write_reg(REG_RANGE, s.range_gain);
		write_reg(REG_ATTACK, s.attack_k);
		write_reg(REG_DECAY, s.decay_k);
		write_reg(REG_RELEASE, s.release_k);
		write_reg(REG_HOLD, {junk[3:0], s.hold_len});
		write_reg(REG_CHANNELS, {junk[24:4], s.chan_count});
		if (poke_unused) write_reg(REG_UNUSED, junk[31:8]);
		cfg_we <= 1'b0;
		regs_now = s;
		@(posedge clk);
	endtask

	// reset values, threshold never reached, sample extremes
	task automatic test_reset_defaults();
		send_frame(make_frame(S_MIN, S_MIN, S_MAX, '0, -24'sd1));
		send_frame(make_frame(S_MAX, S_MAX, S_MIN, 24'sd1, '0));
		send_frame(make_frame('0, 24'sh400000, -24'sh400000, S_MAX, S_MIN));
		send_frame(make_frame(-24'sd1, rand_sample(), rand_sample(), rand_sample(),
			rand_sample()));
	endtask

	// loud burst, then silence through the hold countdown and the glide back
	task automatic test_hold_countdown();
		apply_settings('{thresh: 24'h200000, range_gain: 24'h100000, attack_k: UNITY,
			decay_k: 24'h200000, release_k: 24'h200000, hold_len: 20'd3,
			chan_count: 3'd2}, 1'b0);
		repeat (2) send_frame(make_frame(S_MAX, rand_sample(), rand_sample(), rand_sample(),
			rand_sample()));
		repeat (6) send_frame(make_frame('0, rand_sample(), rand_sample(), rand_sample(),
			rand_sample()));
	endtask

	// coefficients above unity, zero and over-range channel counts, unused index
	task automatic test_register_corners();
		apply_settings('{thresh: '0, range_gain: 24'hFFFFFF, attack_k: 24'hFFFFFF,
			decay_k: 24'hFFFFFF, release_k: 24'hFFFFFF, hold_len: 20'hFFFFF,
			chan_count: 3'd0}, 1'b1);
		repeat (4) send_frame(random_frame());
		apply_settings('{thresh: 24'hFFFFFF, range_gain: '0, attack_k: '0, decay_k: '0,
			release_k: '0, hold_len: '0, chan_count: 3'd7}, 1'b1);
		repeat (4) send_frame(random_frame());
	endtask

	// random settings per phase; one phase runs with no idling on either side
	task automatic test_random_program(int phase_count, int frames_per_phase);
		for (int p = 0; p < phase_count; p++) begin
			apply_settings(random_settings(), $urandom_range(3) == 0);
			steady_flow = (p == 2);
			repeat (frames_per_phase) send_frame(random_frame());
			phases_run++;
		end
		steady_flow = 1'b0;
	endtask

	// receiver holds off while frames keep coming, so the input stalls
	task automatic test_output_stall();
		apply_settings(random_settings(), 1'b0);
		steady_flow = 1'b1;
		stall_budget = HOLD_OFF_LEN;
		repeat (30) send_frame(random_frame());
		steady_flow = 1'b0;
	endtask

	// receiver readiness
	always @(posedge clk) begin
		if (stall_budget > 0) begin
			m_axis_tready <= 1'b0;
			stall_budget <= stall_budget - 1;
		end else if (steady_flow) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= 28);
		end
	end

	task automatic report_field(string name, logic [COEF_BITS-1:0] want_v,
		logic [COEF_BITS-1:0] got_v);
		mismatch_count++;
		$display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want_v, got_v);
	endtask

	// compare each output transfer with the oldest prediction
	always @(posedge clk) begin : result_check
		ducked_frame_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[OUT_RAW-1:0];
			if (expected_q.size() == 0) begin
				mismatch_count++;
				$display("%0t ns: output transfer with nothing expected, data %h", $time, got);
			end else begin
				want = expected_q.pop_front();
				results_checked++;
				if (want.ducking) ducking_seen++;
				for (int ch = 0; ch < MAX_CHANNELS; ch++)
					if (got.ducked[ch] !== want.ducked[ch])
						report_field($sformatf("ducked_%0d", ch), want.ducked[ch], got.ducked[ch]);
				if (got.gain !== want.gain)
					report_field("frame_gain", want.gain, got.gain);
				if (got.ducking !== want.ducking)
					report_field("ducking_flag", COEF_BITS'(want.ducking), COEF_BITS'(got.ducking));
			end
		end
	end

	// run limit
	initial begin
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run limit of %0d cycles reached with %0d results pending", RUN_LIMIT,
			expected_q.size());
		$display("** sidechain_audio_ducker: FAILED **");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_hold_countdown();
		test_register_corners();
		test_random_program(7, 185);
		test_output_stall();
		wait_drained();
		$display("%0d frames sent, %0d results checked, %0d of them ducked, %0d mismatches",
			frames_sent, results_checked, ducking_seen, mismatch_count);
		$display("covered reset values, hold countdown, register corners, %0d random phases, %s",
			phases_run, "long output stall");
		if (mismatch_count == 0)
			$display("** sidechain_audio_ducker: PASSED **");
		else
			$display("** sidechain_audio_ducker: FAILED **");
		$finish;
	end

endmodule
